// ===== hdl/bbam_pkg.sv =====
// Package for the buffer-addressed atomic word memory.
// Holds opcodes, status codes, payload structs and sizing constants; no dependencies.
`default_nettype none
package bbam_pkg;

  localparam int IdLimit    = 64;
  localparam int WordLimit  = 256;
  localparam int IdW        = 6;
  localparam int OffW       = 8;
  localparam int AddrW      = IdW + OffW;
  localparam int SizeW      = 11;
  localparam int CntW       = 7;
  localparam logic [SizeW-1:0] CapBytes = SizeW'(WordLimit * 4);

  typedef enum logic [4:0] {
    OP_ALLOC = 5'd0, OP_RELEASE = 5'd1, OP_LOAD = 5'd2, OP_STORE = 5'd3,
    OP_ALOAD = 5'd4, OP_ASTORE = 5'd5, OP_XCHG = 5'd6, OP_CMPXCHG = 5'd7,
    OP_ADD = 5'd8, OP_SUB = 5'd9, OP_INC = 5'd10, OP_DEC = 5'd11,
    OP_AND = 5'd12, OP_OR = 5'd13, OP_XOR = 5'd14, OP_SMIN = 5'd15,
    OP_SMAX = 5'd16, OP_UMIN = 5'd17, OP_UMAX = 5'd18
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BAD_ACCESS = 3'd1, ST_NO_ID = 3'd2,
    ST_BAD_RELEASE = 3'd3, ST_BAD_OP = 3'd4
  } status_t;

  // States of the memory back part.
  typedef enum logic [1:0] {B_IDLE, B_READ, B_DONE} back_state_t;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [5:0]  buffer_id;
    logic [9:0]  word_offset;
    logic [31:0] operand_value;
    logic [31:0] compare_value;
    logic [10:0] alloc_bytes;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [5:0]  alloc_id;
    logic [2:0]  status;
  } out_item_t;

  // Classified work passed from the front part to the memory back part.
  typedef struct packed {
    logic              mem_op;
    logic [4:0]        opcode;
    logic [AddrW-1:0]  addr;
    logic [31:0]       operand_value;
    logic [31:0]       compare_value;
    logic [5:0]        alloc_id;
    logic [2:0]        status;
  } work_t;

endpackage
`default_nettype wire

// ===== hdl/bbam_front.sv =====
// Front part: id allocation, release and bounds check of each access.
// Depends on bbam_pkg.
`default_nettype none
module bbam_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bbam_pkg::in_item_t in_data,
  output logic                   wk_valid,
  input  wire logic              wk_stall,
  output bbam_pkg::work_t        wk_data
);

  logic [bbam_pkg::IdLimit-1:0]  live_r, live_nxt;
  logic [bbam_pkg::SizeW-1:0]    size_r  [bbam_pkg::IdLimit];
  logic [bbam_pkg::IdW-1:0]      stack_r [bbam_pkg::IdLimit];
  logic [bbam_pkg::CntW-1:0]     cnt_r, cnt_nxt, next_r, next_nxt;
  logic                          wk_valid_r;
  bbam_pkg::work_t               wk_r, wk_nxt;
  logic                          hold_r;
  bbam_pkg::in_item_t            in_r;
  logic [bbam_pkg::SizeW-1:0]    size_rd_r;
  logic [bbam_pkg::IdW-1:0]      top_rd_r;
  logic                          size_we, push_we;
  logic [bbam_pkg::IdW-1:0]      size_idx;
  logic [bbam_pkg::SizeW-1:0]    size_val;
  logic [bbam_pkg::SizeW+1:0]    need;
  logic                          accept, move;

  // A captured item waits for the registered table reads, then moves on
  // once the queue register is free.
  assign in_stall = hold_r;
  assign accept   = in_valid && !hold_r;
  assign move     = hold_r && !(wk_valid_r && wk_stall);
  assign wk_valid = wk_valid_r;
  assign wk_data  = wk_r;
  assign need     = ({3'b0, in_r.word_offset} + 13'd1) << 2;

  // Classify the item and work out the bookkeeping update.
  always_comb begin
    live_nxt = live_r;
    cnt_nxt  = cnt_r;
    next_nxt = next_r;
    size_we  = 1'b0;
    push_we  = 1'b0;
    size_idx = in_r.buffer_id;
    size_val = (in_r.alloc_bytes > bbam_pkg::CapBytes) ? bbam_pkg::CapBytes
                                                       : in_r.alloc_bytes;
    wk_nxt = '0;
    wk_nxt.opcode = in_r.opcode;
    wk_nxt.operand_value = in_r.operand_value;
    wk_nxt.compare_value = in_r.compare_value;
    wk_nxt.addr = {in_r.buffer_id, in_r.word_offset[bbam_pkg::OffW-1:0]};
    wk_nxt.status = bbam_pkg::ST_OK;
    if (in_r.opcode == bbam_pkg::OP_ALLOC) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 7'd1;
        size_idx = top_rd_r;
        size_we = 1'b1;
        live_nxt[top_rd_r] = 1'b1;
        wk_nxt.alloc_id = top_rd_r;
      end else if (next_r < 7'(bbam_pkg::IdLimit)) begin
        next_nxt = next_r + 7'd1;
        size_idx = next_r[bbam_pkg::IdW-1:0];
        size_we = 1'b1;
        live_nxt[size_idx] = 1'b1;
        wk_nxt.alloc_id = size_idx;
      end else begin
        wk_nxt.status = bbam_pkg::ST_NO_ID;
      end
    end else if (in_r.opcode == bbam_pkg::OP_RELEASE) begin
      if (in_r.buffer_id == '0 || !live_r[in_r.buffer_id]) begin
        wk_nxt.status = bbam_pkg::ST_BAD_RELEASE;
      end else begin
        live_nxt[in_r.buffer_id] = 1'b0;
        push_we = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
      end
    end else if (in_r.opcode > bbam_pkg::OP_UMAX) begin
      wk_nxt.status = bbam_pkg::ST_BAD_OP;
    end else if (in_r.buffer_id == '0 || !live_r[in_r.buffer_id] ||
                 need > {2'b0, size_rd_r}) begin
      wk_nxt.status = bbam_pkg::ST_BAD_ACCESS;
    end else begin
      wk_nxt.mem_op = 1'b1;
    end
  end

  // Bookkeeping state, the capture flag and the outgoing queue register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      cnt_r <= '0;
      next_r <= 7'd1;
      hold_r <= 1'b0;
      wk_valid_r <= 1'b0;
    end else begin
      if (move) begin
        live_r <= live_nxt;
        cnt_r <= cnt_nxt;
        next_r <= next_nxt;
      end
      if (accept) begin
        hold_r <= 1'b1;
      end else if (move) begin
        hold_r <= 1'b0;
      end
      if (move) begin
        wk_valid_r <= 1'b1;
      end else if (!wk_stall) begin
        wk_valid_r <= 1'b0;
      end
    end
  end

  // Payload storage and registered table reads; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
      size_rd_r <= size_r[in_data.buffer_id];
      top_rd_r <= stack_r[bbam_pkg::IdW'(cnt_r - 7'd1)];
    end
    if (move) begin
      wk_r <= wk_nxt;
      if (size_we) begin
        size_r[size_idx] <= size_val;
      end
      if (push_we) begin
        stack_r[cnt_r[bbam_pkg::IdW-1:0]] <= in_r.buffer_id;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bbam_back.sv =====
// Back part: word memory read, atomic update and write back.
// Depends on bbam_pkg.
`default_nettype none
module bbam_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               wk_valid,
  output logic                    wk_stall,
  input  wire bbam_pkg::work_t    wk_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bbam_pkg::out_item_t     out_data
);

  logic [31:0]           mem [bbam_pkg::IdLimit * bbam_pkg::WordLimit];
  bbam_pkg::back_state_t st_r, st_nxt;
  bbam_pkg::work_t       w_r;
  logic [31:0]           rd_r, nv;
  bbam_pkg::out_item_t   res_r;
  logic                  take, wr_en, done_load;

  assign take = wk_valid && (st_r == bbam_pkg::B_IDLE);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bbam_pkg::B_IDLE:
        if (wk_valid) st_nxt = wk_data.mem_op ? bbam_pkg::B_READ : bbam_pkg::B_DONE;
      bbam_pkg::B_READ: st_nxt = bbam_pkg::B_DONE;
      bbam_pkg::B_DONE: if (!out_stall) st_nxt = bbam_pkg::B_IDLE;
      default: st_nxt = bbam_pkg::B_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    wk_stall  = (st_r != bbam_pkg::B_IDLE);
    out_valid = (st_r == bbam_pkg::B_DONE);
    done_load = (st_r == bbam_pkg::B_READ);
    wr_en     = done_load && w_r.opcode != bbam_pkg::OP_LOAD &&
                w_r.opcode != bbam_pkg::OP_ALOAD;
  end

  // Atomic operation on the old word.
  always_comb begin
    nv = rd_r;
    unique case (w_r.opcode)
      bbam_pkg::OP_STORE, bbam_pkg::OP_ASTORE, bbam_pkg::OP_XCHG:
        nv = w_r.operand_value;
      bbam_pkg::OP_CMPXCHG: if (rd_r == w_r.compare_value) nv = w_r.operand_value;
      bbam_pkg::OP_ADD: nv = rd_r + w_r.operand_value;
      bbam_pkg::OP_SUB: nv = rd_r - w_r.operand_value;
      bbam_pkg::OP_INC: nv = rd_r + 32'd1;
      bbam_pkg::OP_DEC: nv = rd_r - 32'd1;
      bbam_pkg::OP_AND: nv = rd_r & w_r.operand_value;
      bbam_pkg::OP_OR:  nv = rd_r | w_r.operand_value;
      bbam_pkg::OP_XOR: nv = rd_r ^ w_r.operand_value;
      bbam_pkg::OP_SMIN:
        nv = ($signed(w_r.operand_value) < $signed(rd_r)) ? w_r.operand_value : rd_r;
      bbam_pkg::OP_SMAX:
        nv = ($signed(w_r.operand_value) > $signed(rd_r)) ? w_r.operand_value : rd_r;
      bbam_pkg::OP_UMIN: nv = (w_r.operand_value < rd_r) ? w_r.operand_value : rd_r;
      bbam_pkg::OP_UMAX: nv = (w_r.operand_value > rd_r) ? w_r.operand_value : rd_r;
      default: nv = rd_r;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bbam_pkg::B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Memory port and result register.
  always_ff @(posedge clk) begin
    if (take) begin
      w_r <= wk_data;
      rd_r <= mem[wk_data.addr];
      res_r <= '{read_data: 32'd0, alloc_id: wk_data.alloc_id,
                 status: wk_data.status};
    end
    if (wr_en) begin
      mem[w_r.addr] <= nv;
    end
    if (done_load && w_r.opcode != bbam_pkg::OP_STORE) begin
      res_r.read_data <= rd_r;
    end
  end

  assign out_data = res_r;

endmodule
`default_nettype wire

// ===== hdl/bounded_buffer_atomic_memory.sv =====
// Top level of the buffer-addressed atomic word memory.
// Depends on bbam_pkg, bbam_front and bbam_back.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one command per
//   transfer: allocate, release, plain load and store, or an atomic operation.
//   The result channel (out_valid, out_stall, out_data) returns exactly one
//   result per command, in order.
//   The front part registers the command and reads the size table and the
//   freed-id stack, then, once the queue register is free, updates the id
//   bookkeeping, checks bounds and hands the classified command to a one-entry
//   queue. in_stall is high for at least the cycle after each transfer.
//   The back part registers the word read from memory, applies the atomic
//   operation and writes back in its B_READ state, then holds the result
//   in B_DONE until it is taken. The front part can accept a new command
//   while the back part still works on the previous one; the back part
//   takes one command at a time and stalls the queue until its result is taken.
//   Synchronous reset clears live bits and the freed-id count and sets the next new id to 1.
//   While the receiver stalls, the back part holds its result, the queue fills
//   and in_stall stays high.
`default_nettype none
module bounded_buffer_atomic_memory (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bbam_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bbam_pkg::out_item_t      out_data
);

  logic            wk_valid, wk_stall;
  bbam_pkg::work_t wk_data;

  bbam_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .wk_valid(wk_valid), .wk_stall(wk_stall), .wk_data(wk_data)
  );

  bbam_back u_back (
    .clk(clk), .rst_n(rst_n),
    .wk_valid(wk_valid), .wk_stall(wk_stall), .wk_data(wk_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule
`default_nettype wire
